>>> rtl/rdt_pkg.sv
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants of the route decision table.
// ----------------------------------------------------------------------------
package rdt_pkg;

  localparam int COST_W = 10;
  localparam int HOP_W  = 5;
  localparam int ENT_W  = HOP_W + COST_W;

  localparam logic [COST_W-1:0] COST_INF = '1;
  localparam logic [HOP_W-1:0]  HOP_INF  = '1;

  localparam logic [COST_W-1:0] MAX_COST_RST = 10'd1022;
  localparam logic [HOP_W-1:0]  MAX_HOP_RST  = 5'd30;

  // command codes
  localparam logic [1:0] CMD_UPDATE    = 2'd0;
  localparam logic [1:0] CMD_SET_ID    = 2'd1;
  localparam logic [1:0] CMD_RECOMPUTE = 2'd2;

  // configuration register indexes
  localparam logic REG_MAX_COST = 1'b0;
  localparam logic REG_MAX_HOP  = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SET_ID,
    OP_UPDATE,
    OP_RECOMPUTE
  } op_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [9:0]        dest;
    logic [3:0]        column;
    logic [HOP_W-1:0]  reported_hops;
    logic [COST_W-1:0] reported_cost;
    logic [5:0]        link_cost;
    logic [15:0]       neighbor_id;
  } req_t;

  typedef struct packed {
    logic [9:0]        dest_out;
    logic              reachable;
    logic [HOP_W-1:0]  best_hops;
    logic [COST_W-1:0] best_cost_out;
    logic [3:0]        out_column;
    logic              route_changed;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic update;
    logic issue;
    logic take;
    logic first;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    op_t  kind;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/rdt_stream_if.sv
// ----------------------------------------------------------------------------
// rdt_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface rdt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/route_decision_table.sv
// ----------------------------------------------------------------------------
// route_decision_table
// Distance-vector route selection over a destination by neighbor table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that sets every table entry and
// best route to infinity; no word is taken until it ends. An update word writes
// its table entry first; for it and for a recompute word the row is then
// scanned one column per cycle through the single read port of the hop/cost
// table, then the best route is written back. The result sits in an output
// register, so the next word is taken while a result still waits.
module route_decision_table #(
  parameter int DESTS   = 1024,
  parameter int COLUMNS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  rdt_stream_if.sink                  req,
  rdt_stream_if.source                rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rdt_pkg::COST_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DESTS) + $clog2(COLUMNS);

  rdt_pkg::dp_cmd_t    cmd;
  rdt_pkg::dp_status_t status;
  logic [AW-1:0]       cnt;
  logic                in_ready;
  logic                out_valid;
  rdt_pkg::rsp_t       out_pl;

  rdt_ctrl #(
    .DESTS   (DESTS),
    .COLUMNS (COLUMNS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd),
    .cnt       (cnt)
  );

  rdt_dp #(
    .DESTS   (DESTS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_pl    (req.payload),
    .cmd       (cmd),
    .cnt       (cnt),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (out_valid),
    .rsp_ready (rsp.ready),
    .rsp_pl    (out_pl)
  );

  assign req.ready   = in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_pl;

endmodule

>>> rtl/rdt_ctrl.sv
// ----------------------------------------------------------------------------
// rdt_ctrl
// Sequencer: table clearing pass, entry update, column scan, result hand-off.
// ----------------------------------------------------------------------------
module rdt_ctrl #(
  parameter int DESTS   = 1024,
  parameter int COLUMNS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   in_ready,
  input  rdt_pkg::dp_status_t                    status,
  output rdt_pkg::dp_cmd_t                       cmd,
  output logic [$clog2(DESTS)+$clog2(COLUMNS)-1:0] cnt
);

  localparam int DW        = $clog2(DESTS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int AW        = DW + CW;
  localparam int TBL_DEPTH = DESTS * (2 ** CW);

  localparam logic [AW-1:0] CLR_LAST = AW'(TBL_DEPTH - 1);
  localparam logic [AW-1:0] SCAN_END = AW'(COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.clear  = (state == S_CLEAR);
    cmd.update = (state == S_UPDATE);
    cmd.issue  = (state == S_SCAN) && (cnt < SCAN_END);
    cmd.take   = (state == S_SCAN) && (cnt != '0);
    cmd.first  = (state == S_SCAN) && (cnt == AW'(1));
    cmd.finish = (state == S_DONE) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cnt == CLR_LAST) begin
            state <= S_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (req_valid) begin
            unique case (status.kind)
              rdt_pkg::OP_UPDATE:    state <= S_UPDATE;
              rdt_pkg::OP_RECOMPUTE: state <= S_SCAN;
              default:               state <= S_IDLE;
            endcase
          end
        end
        S_UPDATE: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt == SCAN_END) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_DONE: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rdt_dp.sv
// ----------------------------------------------------------------------------
// rdt_dp
// Datapath: hop/cost table, best-route memory, neighbor ids, min search and
// output register.
// ----------------------------------------------------------------------------
module rdt_dp #(
  parameter int DESTS   = 1024,
  parameter int COLUMNS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rdt_pkg::req_t                          req_pl,
  input  rdt_pkg::dp_cmd_t                       cmd,
  input  logic [$clog2(DESTS)+$clog2(COLUMNS)-1:0] cnt,
  output rdt_pkg::dp_status_t                    status,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic [rdt_pkg::COST_W-1:0]             cfg_data,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output rdt_pkg::rsp_t                          rsp_pl
);

  localparam int DW        = $clog2(DESTS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int AW        = DW + CW;
  localparam int TBL_DEPTH = DESTS * (2 ** CW);

  // configuration
  logic [rdt_pkg::COST_W-1:0] max_cost;
  logic [rdt_pkg::HOP_W-1:0]  max_hop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cost <= rdt_pkg::MAX_COST_RST;
      max_hop  <= rdt_pkg::MAX_HOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdt_pkg::REG_MAX_COST: max_cost <= cfg_data;
        rdt_pkg::REG_MAX_HOP:  max_hop  <= cfg_data[rdt_pkg::HOP_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode straight off the input word
  logic col_ok;
  logic dest_ok;

  always_comb begin
    col_ok  = 32'(req_pl.column) < 32'(COLUMNS);
    dest_ok = 32'(req_pl.dest) < 32'(DESTS);
    case (req_pl.cmd)
      rdt_pkg::CMD_SET_ID:    status.kind = col_ok ? rdt_pkg::OP_SET_ID : rdt_pkg::OP_NONE;
      rdt_pkg::CMD_UPDATE:    status.kind = (col_ok && dest_ok) ? rdt_pkg::OP_UPDATE
                                                                : rdt_pkg::OP_NONE;
      rdt_pkg::CMD_RECOMPUTE: status.kind = dest_ok ? rdt_pkg::OP_RECOMPUTE
                                                    : rdt_pkg::OP_NONE;
      default:                status.kind = rdt_pkg::OP_NONE;
    endcase
  end

  // latched item
  logic [DW-1:0]              dest_l;
  logic [CW-1:0]              col_l;
  logic [rdt_pkg::HOP_W-1:0]  upd_hop;
  logic [rdt_pkg::COST_W-1:0] upd_cost;
  logic [rdt_pkg::HOP_W:0]    hop_sum;
  logic [rdt_pkg::COST_W:0]   cost_sum;

  always_comb begin
    hop_sum  = {1'b0, req_pl.reported_hops} + (rdt_pkg::HOP_W+1)'(1);
    cost_sum = {1'b0, req_pl.reported_cost}
             + (rdt_pkg::COST_W+1)'(req_pl.link_cost);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dest_l   <= DW'(req_pl.dest);
      col_l    <= CW'(req_pl.column);
      upd_hop  <= (hop_sum > {1'b0, rdt_pkg::HOP_INF}) ? rdt_pkg::HOP_INF
                                                        : hop_sum[rdt_pkg::HOP_W-1:0];
      upd_cost <= (cost_sum > {1'b0, rdt_pkg::COST_INF}) ? rdt_pkg::COST_INF
                                                          : cost_sum[rdt_pkg::COST_W-1:0];
    end
  end

  // neighbor ids
  logic [15:0] col_ids [COLUMNS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COLUMNS; i++) begin
        col_ids[i] <= '0;
      end
    end else if (cmd.accept && status.kind == rdt_pkg::OP_SET_ID) begin
      col_ids[CW'(req_pl.column)] <= req_pl.neighbor_id;
    end
  end

  // hop/cost table, one entry per destination and column: {hop, cost}
  logic [rdt_pkg::ENT_W-1:0] tbl_mem [TBL_DEPTH];
  logic [rdt_pkg::ENT_W-1:0] tbl_rd;
  logic [rdt_pkg::ENT_W-1:0] tbl_wd;
  logic [AW-1:0]             tbl_wa;
  logic                      tbl_we;
  logic [CW-1:0]             tk_col;

  always_comb begin
    tbl_we = cmd.clear || cmd.update;
    tbl_wa = cmd.clear ? cnt : {dest_l, col_l};
    tbl_wd = cmd.clear ? {rdt_pkg::HOP_INF, rdt_pkg::COST_INF} : {upd_hop, upd_cost};
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd.issue) begin
      tbl_rd <= tbl_mem[{dest_l, cnt[CW-1:0]}];
      tk_col <= cnt[CW-1:0];
    end
  end

  // best-route memory per destination: {hop, cost}
  logic [rdt_pkg::ENT_W-1:0] best_mem [DESTS];
  logic [rdt_pkg::ENT_W-1:0] best_rd;
  logic                      best_we;
  logic [DW-1:0]             best_wa;
  logic [rdt_pkg::ENT_W-1:0] best_wd;

  // least-cost search over the row
  logic [rdt_pkg::COST_W-1:0] min_cost;
  logic [rdt_pkg::HOP_W-1:0]  min_hop;
  logic [CW-1:0]              min_col;
  logic [15:0]                min_id;
  logic [rdt_pkg::COST_W-1:0] rd_cost;
  logic [rdt_pkg::HOP_W-1:0]  rd_hop;
  logic [15:0]                rd_id;
  logic                       better;

  always_comb begin
    rd_cost = tbl_rd[rdt_pkg::COST_W-1:0];
    rd_hop  = tbl_rd[rdt_pkg::ENT_W-1:rdt_pkg::COST_W];
    rd_id   = col_ids[tk_col];
    // ties go to the larger neighbor id
    better  = cmd.first || (rd_cost < min_cost) || (rd_cost == min_cost && rd_id > min_id);
  end

  always_ff @(posedge clk) begin
    if (cmd.take && better) begin
      min_cost <= rd_cost;
      min_hop  <= rd_hop;
      min_col  <= tk_col;
      min_id   <= rd_id;
    end
  end

  // limits and change check
  logic [rdt_pkg::COST_W-1:0] lim_cost;
  logic [rdt_pkg::HOP_W-1:0]  lim_hop;
  logic                       reach;
  logic [rdt_pkg::COST_W-1:0] res_cost;
  logic [rdt_pkg::HOP_W-1:0]  res_hop;
  logic                       changed;

  always_comb begin
    lim_cost = (min_cost > max_cost) ? rdt_pkg::COST_INF : min_cost;
    lim_hop  = (min_hop > max_hop) ? rdt_pkg::HOP_INF : min_hop;
    reach    = (lim_hop != rdt_pkg::HOP_INF) && (lim_cost != rdt_pkg::COST_INF);
    res_cost = reach ? lim_cost : rdt_pkg::COST_INF;
    res_hop  = reach ? lim_hop : rdt_pkg::HOP_INF;
    changed  = (res_hop != best_rd[rdt_pkg::ENT_W-1:rdt_pkg::COST_W])
            || (res_cost != best_rd[rdt_pkg::COST_W-1:0]);
    best_we  = cmd.clear || cmd.finish;
    best_wa  = cmd.clear ? cnt[AW-1:CW] : dest_l;
    best_wd  = cmd.clear ? {rdt_pkg::HOP_INF, rdt_pkg::COST_INF} : {res_hop, res_cost};
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_wa] <= best_wd;
    end
    best_rd <= best_mem[dest_l];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_pl.dest_out      <= 10'(dest_l);
      rsp_pl.reachable     <= reach;
      rsp_pl.best_hops     <= res_hop;
      rsp_pl.best_cost_out <= res_cost;
      rsp_pl.out_column    <= 4'(min_col);
      rsp_pl.route_changed <= changed;
    end
  end

  assign status.out_busy = rsp_valid && !rsp_ready;

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp_valid)
    else $error("finished route not presented");

  a_unreach_inf: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_pl.reachable) |->
      (rsp_pl.best_hops == rdt_pkg::HOP_INF && rsp_pl.best_cost_out == rdt_pkg::COST_INF))
    else $error("unreachable route without infinities");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(tbl_we && cmd.issue))
    else $error("table write during scan read");

endmodule

>>> tb/sv/route_decision_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_decision_table_tb
// Self-checking bench for the route decision table. A short table of corner
// words runs first, then random update, recompute, neighbor id and unused
// words over several cost and hop limits. Both channels idle at random; each
// result word is compared with the table's expected word or a behavioral model.
// ----------------------------------------------------------------------------
module route_decision_table_tb;

  localparam int N_DEST      = 1024;
  localparam int N_COL       = 16;
  localparam int N_PHASE     = 6;
  localparam int PHASE_WORDS = 275;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;
  localparam int WD_LIMIT    = 70000;
  localparam int N_DIR       = 22;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    rdt_pkg::req_t w;
    logic          typed;
    rdt_pkg::rsp_t exp;
  } dir_row_t;

  localparam rdt_pkg::rsp_t NO_EXP = '0;

  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // fresh table: nothing reachable
    '{'{rdt_pkg::CMD_RECOMPUTE, 10'd0, 4'd0, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b1,
      '{10'd0, 1'b0, rdt_pkg::HOP_INF, rdt_pkg::COST_INF, 4'd0, 1'b0}},
    '{'{rdt_pkg::CMD_RECOMPUTE, 10'd1023, 4'd0, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b1,
      '{10'd1023, 1'b0, rdt_pkg::HOP_INF, rdt_pkg::COST_INF, 4'd0, 1'b0}},
    '{'{rdt_pkg::CMD_UPDATE, 10'd5, 4'd3, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b1,
      '{10'd5, 1'b1, 5'd1, 10'd0, 4'd3, 1'b1}},
    // sums saturate, route lost again
    '{'{rdt_pkg::CMD_UPDATE, 10'd5, 4'd3, 5'd31, 10'd1023, 6'd63, 16'h0000}, 1'b1,
      '{10'd5, 1'b0, rdt_pkg::HOP_INF, rdt_pkg::COST_INF, 4'd0, 1'b1}},
    // cost at the limit but hops over it
    '{'{rdt_pkg::CMD_UPDATE, 10'd6, 4'd15, 5'd30, 10'd1000, 6'd22, 16'h0000}, 1'b1,
      '{10'd6, 1'b0, rdt_pkg::HOP_INF, rdt_pkg::COST_INF, 4'd15, 1'b0}},
    '{'{rdt_pkg::CMD_UPDATE, 10'd7, 4'd0, 5'd29, 10'd1000, 6'd22, 16'h0000}, 1'b1,
      '{10'd7, 1'b1, 5'd30, 10'd1022, 4'd0, 1'b1}},
    '{'{rdt_pkg::CMD_UPDATE, 10'd8, 4'd1, 5'd0, 10'd1000, 6'd23, 16'h0000}, 1'b1,
      '{10'd8, 1'b0, rdt_pkg::HOP_INF, rdt_pkg::COST_INF, 4'd0, 1'b0}},
    '{'{CMD_UNUSED, 10'd7, 4'd5, 5'd1, 10'd1, 6'd1, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_RECOMPUTE, 10'd7, 4'd0, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b1,
      '{10'd7, 1'b1, 5'd30, 10'd1022, 4'd0, 1'b0}},
    // neighbor ids and ties
    '{'{rdt_pkg::CMD_SET_ID, 10'd0, 4'd0, 5'd0, 10'd0, 6'd0, 16'hffff}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_SET_ID, 10'd0, 4'd9, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_SET_ID, 10'd0, 4'd15, 5'd0, 10'd0, 6'd0, 16'hffff}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd9, 4'd9, 5'd2, 10'd10, 6'd5, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd9, 4'd4, 5'd3, 10'd12, 6'd3, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_SET_ID, 10'd0, 4'd4, 5'd0, 10'd0, 6'd0, 16'h8000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_RECOMPUTE, 10'd9, 4'd0, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd9, 4'd15, 5'd1, 10'd15, 6'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd1023, 4'd15, 5'd31, 10'd1023, 6'd63, 16'h0000},
      1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd0, 4'd0, 5'd0, 10'd0, 6'd63, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_SET_ID, 10'd0, 4'd15, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_RECOMPUTE, 10'd9, 4'd0, 5'd0, 10'd0, 6'd0, 16'h0000}, 1'b0, NO_EXP},
    '{'{rdt_pkg::CMD_UPDATE, 10'd682, 4'd10, 5'd21, 10'd682, 6'd42, 16'h5555},
      1'b0, NO_EXP}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [rdt_pkg::COST_W-1:0] cfg_data;

  rdt_stream_if #(.payload_t(rdt_pkg::req_t)) req_ch ();
  rdt_stream_if #(.payload_t(rdt_pkg::rsp_t)) rsp_ch ();

  route_decision_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model of the routing table
  logic [rdt_pkg::COST_W-1:0] path_cost  [N_DEST][N_COL];
  logic [rdt_pkg::HOP_W-1:0]  path_hops  [N_DEST][N_COL];
  logic [15:0]                nbr_id     [N_COL];
  logic [rdt_pkg::COST_W-1:0] route_cost [N_DEST];
  logic [rdt_pkg::HOP_W-1:0]  route_hops [N_DEST];
  logic [rdt_pkg::COST_W-1:0] lim_cost;
  logic [rdt_pkg::HOP_W-1:0]  lim_hop;
  rdt_pkg::rsp_t              route_q [$];

  bit            cur_typed;
  rdt_pkg::rsp_t cur_exp;
  bit            hold_ask = 1'b0;
  int unsigned   n_taken = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_reach = 0;
  int unsigned   n_changed = 0;
  int unsigned   n_update = 0;
  int unsigned   n_recomp = 0;
  int unsigned   n_setid = 0;
  int unsigned   n_ignored = 0;
  int unsigned   n_mismatch = 0;
  int unsigned   n_errors = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic route_predict(input rdt_pkg::req_t w, output bit emits,
                               output rdt_pkg::rsp_t r);
    int unsigned                h;
    int unsigned                c;
    int unsigned                sel;
    int                         j;
    logic [rdt_pkg::COST_W-1:0] least;
    logic [rdt_pkg::HOP_W-1:0]  hops;
    logic                       reach;
    emits = 1'b0;
    r = '0;
    if (w.cmd == rdt_pkg::CMD_SET_ID) begin
      nbr_id[w.column] = w.neighbor_id;
    end else if (w.cmd == rdt_pkg::CMD_UPDATE || w.cmd == rdt_pkg::CMD_RECOMPUTE) begin
      if (w.cmd == rdt_pkg::CMD_UPDATE) begin
        h = w.reported_hops + 32'd1;
        c = w.reported_cost + w.link_cost;
        path_hops[w.dest][w.column] = (h > rdt_pkg::HOP_INF) ? rdt_pkg::HOP_INF
                                                              : h[rdt_pkg::HOP_W-1:0];
        path_cost[w.dest][w.column] = (c > rdt_pkg::COST_INF) ? rdt_pkg::COST_INF
                                                               : c[rdt_pkg::COST_W-1:0];
      end
      // least cost wins, ties go to the larger neighbor id
      sel = 0;
      least = path_cost[w.dest][0];
      for (j = 1; j < N_COL; j++) begin
        if (path_cost[w.dest][4'(j)] < least ||
            (path_cost[w.dest][4'(j)] == least && nbr_id[4'(j)] > nbr_id[4'(sel)])) begin
          least = path_cost[w.dest][4'(j)];
          sel = j;
        end
      end
      if (least > lim_cost) least = rdt_pkg::COST_INF;
      hops = path_hops[w.dest][4'(sel)];
      if (hops > lim_hop) hops = rdt_pkg::HOP_INF;
      reach = !(hops == rdt_pkg::HOP_INF || least == rdt_pkg::COST_INF);
      if (!reach) begin
        hops = rdt_pkg::HOP_INF;
        least = rdt_pkg::COST_INF;
      end
      r.dest_out      = w.dest;
      r.reachable     = reach;
      r.best_hops     = hops;
      r.best_cost_out = least;
      r.out_column    = sel[3:0];
      r.route_changed = (hops != route_hops[w.dest]) || (least != route_cost[w.dest]);
      route_hops[w.dest] = hops;
      route_cost[w.dest] = least;
      emits = 1'b1;
    end
  endtask

  // offer one word after a random gap, return at the falling edge after it is taken
  task automatic send_word(input rdt_pkg::req_t w, input bit typed, input rdt_pkg::rsp_t exp,
                           input bit calm);
    int unsigned gap;
    int unsigned seen;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.payload <= w;
    req_ch.valid <= 1'b1;
    cur_typed = typed;
    cur_exp = exp;
    seen = n_taken;
    do @(negedge clk); while (n_taken == seen);
  endtask

  always @(posedge clk) begin : monitor
    bit            emits;
    rdt_pkg::rsp_t pred;
    rdt_pkg::rsp_t want;
    rdt_pkg::rsp_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (route_q.size() == 0) begin
          n_errors++;
          if (n_mismatch < 10)
            $display("result word for dest %0d with nothing expected", got.dest_out);
          n_mismatch++;
        end else begin
          want = route_q.pop_front();
          n_checked++;
          if (got.reachable) n_reach++;
          if (got.route_changed) n_changed++;
          if (got !== want) begin
            n_errors++;
            if (n_mismatch < 10) begin
              $display("mismatch: expected dest %0d reach %0d hops %0d cost %0d col %0d chg %0d",
                       want.dest_out, want.reachable, want.best_hops, want.best_cost_out,
                       want.out_column, want.route_changed);
              $display("          got      dest %0d reach %0d hops %0d cost %0d col %0d chg %0d",
                       got.dest_out, got.reachable, got.best_hops, got.best_cost_out,
                       got.out_column, got.route_changed);
            end
            n_mismatch++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        route_predict(req_ch.payload, emits, pred);
        if (emits) route_q.push_back(cur_typed ? cur_exp : pred);
        case (req_ch.payload.cmd)
          rdt_pkg::CMD_UPDATE:    n_update++;
          rdt_pkg::CMD_RECOMPUTE: n_recomp++;
          rdt_pkg::CMD_SET_ID:    n_setid++;
          default:                n_ignored++;
        endcase
        n_taken++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results pending",
                 WD_LIMIT, route_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side pacing, with one long hold-off on request
  initial begin : resp_pacer
    int unsigned r;
    int unsigned n;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_ask) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_ask = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rsp_ch.ready <= 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 90) begin
          rsp_ch.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else if (r < 98) begin
          rsp_ch.ready <= 1'b0;
          n = $urandom_range(4, 12);
        end else begin
          rsp_ch.ready <= 1'b0;
          n = $urandom_range(20, 80);
        end
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    rdt_pkg::req_t              w;
    int unsigned                phase;
    int unsigned                done;
    int unsigned                r;
    int                         t;
    int                         lc;
    int                         rc;
    int                         d;
    int                         k;
    bit                         calm_run;
    logic [rdt_pkg::COST_W-1:0] cost_set [N_PHASE];
    logic [rdt_pkg::HOP_W-1:0]  hop_set  [N_PHASE];
    logic [9:0]                 dest_pool [8];

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_we = 1'b0;
    cfg_index = rdt_pkg::REG_MAX_COST;
    cfg_data = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    lim_cost = rdt_pkg::MAX_COST_RST;
    lim_hop = rdt_pkg::MAX_HOP_RST;
    for (d = 0; d < N_DEST; d++) begin
      for (k = 0; k < N_COL; k++) begin
        path_cost[10'(d)][4'(k)] = rdt_pkg::COST_INF;
        path_hops[10'(d)][4'(k)] = rdt_pkg::HOP_INF;
      end
      route_cost[10'(d)] = rdt_pkg::COST_INF;
      route_hops[10'(d)] = rdt_pkg::HOP_INF;
    end
    for (k = 0; k < N_COL; k++) nbr_id[4'(k)] = '0;

    cost_set[0] = rdt_pkg::MAX_COST_RST;  hop_set[0] = rdt_pkg::MAX_HOP_RST;
    cost_set[1] = rdt_pkg::COST_INF;      hop_set[1] = rdt_pkg::HOP_INF;
    cost_set[2] = 10'd0;                  hop_set[2] = 5'd0;
    cost_set[3] = 10'($urandom_range(20, 1000));  hop_set[3] = 5'($urandom_range(2, 29));
    cost_set[4] = 10'd200;                hop_set[4] = 5'd6;
    cost_set[5] = 10'($urandom_range(1, 1022));   hop_set[5] = 5'($urandom_range(1, 30));
    dest_pool[0] = 10'd0;
    dest_pool[1] = 10'd1023;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < N_PHASE; phase++) begin
      // let the block go quiet before the limits move
      req_ch.valid <= 1'b0;
      while (route_q.size() != 0) @(negedge clk);
      repeat (SETTLE) @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= rdt_pkg::REG_MAX_COST;
      cfg_data <= cost_set[3'(phase)];
      @(negedge clk);
      cfg_index <= rdt_pkg::REG_MAX_HOP;
      cfg_data <= {{(rdt_pkg::COST_W-rdt_pkg::HOP_W){1'b0}}, hop_set[3'(phase)]};
      @(negedge clk);
      cfg_we <= 1'b0;
      lim_cost = cost_set[3'(phase)];
      lim_hop = hop_set[3'(phase)];
      for (k = 2; k < 8; k++) dest_pool[3'(k)] = 10'($urandom);

      if (phase == 0) begin
        for (k = 0; k < N_DIR; k++)
          send_word(DIR_TAB[5'(k)].w, DIR_TAB[5'(k)].typed, DIR_TAB[5'(k)].exp, 1'b0);
      end

      done = 0;
      calm_run = 1'b0;
      while (done < PHASE_WORDS) begin
        if (done % 50 == 0) calm_run = ($urandom_range(0, 3) == 0);
        // result side stalls for a long stretch while words keep coming
        if (phase == 3 && done == 60) hold_ask = 1'b1;

        r = $urandom_range(0, 99);
        if (r < 55) w.cmd = rdt_pkg::CMD_UPDATE;
        else if (r < 72) w.cmd = rdt_pkg::CMD_RECOMPUTE;
        else if (r < 92) w.cmd = rdt_pkg::CMD_SET_ID;
        else w.cmd = CMD_UNUSED;
        w.dest = ($urandom_range(0, 99) < 85) ? dest_pool[3'($urandom_range(0, 7))]
                                              : 10'($urandom);
        w.column = 4'($urandom);

        r = $urandom_range(0, 99);
        if (r < 50) begin
          w.reported_hops = 5'($urandom_range(0, 6));
        end else if (r < 70) begin
          t = int'(lim_hop) - 2;
          if (t < 0) t = 0;
          w.reported_hops = 5'($urandom_range(t, lim_hop));
        end else if (r < 85) begin
          w.reported_hops = ($urandom_range(0, 1) == 1) ? 5'd30 : rdt_pkg::HOP_INF;
        end else begin
          w.reported_hops = 5'($urandom);
        end

        r = $urandom_range(0, 99);
        if (r < 40) begin
          rc = $urandom_range(0, 15);
          lc = $urandom_range(0, 3);
        end else if (r < 60) begin
          rc = $urandom_range(0, 1023);
          lc = $urandom_range(0, 63);
        end else if (r < 80) begin
          // land the sum just around the cost limit
          t = int'(lim_cost) - 1 + int'($urandom_range(0, 2));
          if (t < 0) t = 0;
          lc = $urandom_range(0, 63);
          if (lc > t) lc = t;
          rc = t - lc;
          if (rc > 1023) rc = 1023;
        end else if (r < 90) begin
          rc = ($urandom_range(0, 1) == 1) ? 1023 : $urandom_range(990, 1023);
          lc = $urandom_range(0, 63);
        end else begin
          rc = 0;
          lc = 63;
        end
        w.reported_cost = rc[rdt_pkg::COST_W-1:0];
        w.link_cost = lc[5:0];

        r = $urandom_range(0, 99);
        if (r < 50) w.neighbor_id = 16'($urandom_range(0, 3));
        else if (r < 70) w.neighbor_id = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
        else w.neighbor_id = 16'($urandom);

        send_word(w, 1'b0, NO_EXP, calm_run || hold_ask);
        done++;
      end
    end

    req_ch.valid <= 1'b0;
    while (route_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    n_errors += route_q.size();
    $display("covered %0d updates, %0d recomputes, %0d id writes, %0d ignored words, %0d limits",
             n_update, n_recomp, n_setid, n_ignored, N_PHASE);
    $display("checked %0d routes: %0d reachable, %0d changed, %0d mismatches",
             n_checked, n_reach, n_changed, n_mismatch);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
